[rtl/ufrc_pkg.sv]
package ufrc_pkg;

   localparam int NODE_W        = 10;
   localparam int RANK_W        = 4;
   localparam int NODES_DEFAULT = 1024;
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 24;

   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   localparam logic KIND_FIND = 1'b0;
   localparam logic KIND_JOIN = 1'b1;

   // One word of the node store: the rank only matters while the node is a root.
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [NODE_W-1:0] parent;
   } entry_type;

   // Access request from the control sequencer to the node store.
   typedef struct packed {
      logic              rd_en;
      logic [NODE_W-1:0] rd_node;
      logic              wr_en;
      logic [NODE_W-1:0] wr_node;
      entry_type         wr_entry;
   } store_req_type;

endpackage

[rtl/ufrc_store.sv]
module ufrc_store import ufrc_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type req,
   output entry_type     rd_entry,
   output logic          ready
);

   localparam int ADDR_W = $clog2(NODES);

   entry_type mem [NODES];

   logic [ADDR_W-1:0] clr_idx_ff, clr_idx_in;
   logic              clearing_ff, clearing_in;
   entry_type         rd_entry_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;

   // After reset every entry is swept to "own parent, rank zero".
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == ADDR_W'(NODES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         wr_en          = 1'b1;
         wr_addr        = clr_idx_ff;
         wr_data.rank   = '0;
         wr_data.parent = NODE_W'(clr_idx_ff);
      end else begin
         wr_en   = req.wr_en;
         wr_addr = ADDR_W'(req.wr_node);
         wr_data = req.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         rd_entry_ff <= mem[ADDR_W'(req.rd_node)];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign ready    = ~clearing_ff;

endmodule

[rtl/union_find_rank_compress.sv]
// Each transaction walks node_a's path to its root and compresses it, then does the same for
// node_b; every hop of the walks and of the compression passes uses the single node-store read port.
// Throughput: one transaction at a time; the next is taken once the result is in the output
// register. Out-of-range nodes skip the store and go straight to the result.
// Reset: synchronous; a clearing pass over all NODES entries follows, with req_tready held low.
module union_find_rank_compress import ufrc_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // node_a [9:0], node_b [19:10], zero [23:20]
   input  logic                   req_tuser,  // kind [0]: 0 find pair, 1 join
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // root_a [9:0], root_b [19:10], same_set [20],
                                              // merged [21], zero [23:22]
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_COMP,
      ST_LINK,
      ST_BUMP,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic                      kind_ff, kind_in;
   logic [NODE_W-1:0]         node_a_ff, node_a_in;
   logic [NODE_W-1:0]         node_b_ff, node_b_in;
   logic [NODE_W-1:0]         cur_ff, cur_in;
   logic                      sel_b_ff, sel_b_in;
   logic [NODE_W-1:0]         root_a_ff, root_a_in;
   logic [NODE_W-1:0]         root_b_ff, root_b_in;
   logic [RANK_W-1:0]         rank_a_ff, rank_a_in;
   logic [RANK_W-1:0]         rank_b_ff, rank_b_in;
   logic                      merged_ff, merged_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   store_req_type             store_req;
   entry_type                 rd_entry;
   logic                      store_ready;

   logic [NODE_W-1:0]         req_node_a;
   logic [NODE_W-1:0]         req_node_b;
   logic                      req_in_range;
   logic [NODE_W-1:0]         root_cur;
   logic                      same_set;

   // The store holds parent pointer and rank together in one synchronous memory.
   ufrc_store #(
      .NODES (NODES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (store_req),
      .rd_entry (rd_entry),
      .ready    (store_ready)
   );

   assign req_node_a   = req_tdata[NODE_W-1:0];
   assign req_node_b   = req_tdata[2*NODE_W-1:NODE_W];
   assign req_in_range = (32'(req_node_a) < NODES) && (32'(req_node_b) < NODES);

   assign req_tready = (state_ff == ST_IDLE) && store_ready;

   // Root of the path currently being walked or compressed.
   assign root_cur = sel_b_ff ? root_b_ff : root_a_ff;
   assign same_set = (root_a_ff == root_b_ff);

   // Sequencer. Every step issues at most one read and one write to the store. The read data
   // arrives in the next cycle, when the sequencer decides the next hop. A write never targets
   // the entry read in the same cycle, since a hop always moves to a different node.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      node_a_in    = node_a_ff;
      node_b_in    = node_b_ff;
      cur_in       = cur_ff;
      sel_b_in     = sel_b_ff;
      root_a_in    = root_a_ff;
      root_b_in    = root_b_ff;
      rank_a_in    = rank_a_ff;
      rank_b_in    = rank_b_ff;
      merged_in    = merged_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      store_req    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in   = req_tuser;
               node_a_in = req_node_a;
               node_b_in = req_node_b;
               merged_in = 1'b0;
               if (req_in_range) begin
                  // Start the walk from node_a.
                  cur_in            = req_node_a;
                  sel_b_in          = 1'b0;
                  store_req.rd_en   = 1'b1;
                  store_req.rd_node = req_node_a;
                  state_in          = ST_WALK;
               end else begin
                  // An index outside the store leaves all state untouched and echoes the nodes.
                  root_a_in = req_node_a;
                  root_b_in = req_node_b;
                  state_in  = ST_DONE;
               end
            end
         end

         ST_WALK: begin
            if (rd_entry.parent == cur_ff) begin
               // Root reached: record it with its rank, then walk again from the start node.
               if (sel_b_ff) begin
                  root_b_in = cur_ff;
                  rank_b_in = rd_entry.rank;
                  cur_in    = node_b_ff;
               end else begin
                  root_a_in = cur_ff;
                  rank_a_in = rd_entry.rank;
                  cur_in    = node_a_ff;
               end
               store_req.rd_en   = 1'b1;
               store_req.rd_node = sel_b_ff ? node_b_ff : node_a_ff;
               state_in          = ST_COMP;
            end else begin
               cur_in            = rd_entry.parent;
               store_req.rd_en   = 1'b1;
               store_req.rd_node = rd_entry.parent;
            end
         end

         ST_COMP: begin
            if (cur_ff == root_cur) begin
               if (!sel_b_ff) begin
                  sel_b_in          = 1'b1;
                  cur_in            = node_b_ff;
                  store_req.rd_en   = 1'b1;
                  store_req.rd_node = node_b_ff;
                  state_in          = ST_WALK;
               end else if (kind_ff == KIND_JOIN && !same_set) begin
                  state_in = ST_LINK;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               // Point this node straight at the root; its rank is kept as read.
               store_req.wr_en           = 1'b1;
               store_req.wr_node         = cur_ff;
               store_req.wr_entry.rank   = rd_entry.rank;
               store_req.wr_entry.parent = root_cur;
               cur_in                    = rd_entry.parent;
               store_req.rd_en           = 1'b1;
               store_req.rd_node         = rd_entry.parent;
            end
         end

         ST_LINK: begin
            merged_in       = 1'b1;
            store_req.wr_en = 1'b1;
            if (rank_a_ff < rank_b_ff) begin
               store_req.wr_node         = root_a_ff;
               store_req.wr_entry.rank   = rank_a_ff;
               store_req.wr_entry.parent = root_b_ff;
               state_in                  = ST_DONE;
            end else begin
               store_req.wr_node         = root_b_ff;
               store_req.wr_entry.rank   = rank_b_ff;
               store_req.wr_entry.parent = root_a_ff;
               // On a tie the surviving root grows by one, saturating at the top rank.
               if (rank_a_ff == rank_b_ff && rank_a_ff != RANK_MAX) begin
                  state_in = ST_BUMP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_BUMP: begin
            store_req.wr_en           = 1'b1;
            store_req.wr_node         = root_a_ff;
            store_req.wr_entry.rank   = rank_a_ff + 1'b1;
            store_req.wr_entry.parent = root_a_ff;
            state_in                  = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = {2'b00, merged_ff, same_set, root_b_ff, root_a_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      node_a_ff    <= node_a_in;
      node_b_ff    <= node_b_in;
      cur_ff       <= cur_in;
      sel_b_ff     <= sel_b_in;
      root_a_ff    <= root_a_in;
      root_b_ff    <= root_b_in;
      rank_a_ff    <= rank_a_in;
      rank_b_ff    <= rank_b_in;
      merged_ff    <= merged_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A merge only ever happens between two different sets.
   a_merge_not_same: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2*NODE_W] && rsp_tdata[2*NODE_W+1]))
      else $error("merged reported for a pair already in one set");

   // The store's read data would be stale if a write hit the entry being read.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (store_req.rd_en && store_req.wr_en) |-> (store_req.rd_node != store_req.wr_node))
      else $error("store read and write to the same entry in one cycle");

   // Exactly one transaction is in work at a time.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction accepted while one is in work");

endmodule
